@@ hw/rtl/usr_pkg.sv @@
package usr_pkg;

    typedef enum logic [1:0] {
        ACT_DATA     = 2'd0,
        ACT_SET_ADDR = 2'd1,
        ACT_CONFIG   = 2'd2,
        ACT_ACK      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PLAN_NONE,
        PLAN_SINGLE,
        PLAN_STREAM
    } plan_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } seq_state_t;

    localparam logic [2:0] STS_OK            = 3'd0;
    localparam logic [2:0] STS_BAD_DESC      = 3'd1;
    localparam logic [2:0] STS_NO_STATUS     = 3'd2;
    localparam logic [2:0] STS_BAD_REQUEST   = 3'd3;
    localparam logic [2:0] STS_VENDOR        = 3'd4;
    localparam logic [2:0] STS_BAD_TYPE      = 3'd5;

    localparam logic [7:0] RT_STD_OUT        = 8'h00;
    localparam logic [7:0] RT_STD_IN         = 8'h80;
    localparam logic [7:0] RT_TYPE_MASK      = 8'h60;
    localparam logic [7:0] RT_TYPE_VENDOR    = 8'h40;

    localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
    localparam logic [7:0] REQ_GET_DESC      = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;

    localparam logic [7:0] DT_DEVICE         = 8'd1;
    localparam logic [7:0] DT_CONFIG         = 8'd2;
    localparam logic [7:0] DT_STRING         = 8'd3;
    localparam logic [7:0] DT_QUALIFIER      = 8'd6;

    localparam logic [7:0] STR_LANG          = 8'd0;
    localparam logic [7:0] STR_MAKER         = 8'd7;
    localparam logic [7:0] STR_PRODUCT       = 8'd8;
    localparam logic [7:0] CFG_SHORT_LEN     = 8'd9;

    localparam logic [7:0] DEV_BASE          = 8'd0;
    localparam logic [7:0] CFG_BASE          = 8'd18;
    localparam logic [7:0] LANG_BASE         = 8'd50;
    localparam logic [7:0] MAKER_BASE        = 8'd54;
    localparam logic [7:0] PROD_BASE         = 8'd98;
    localparam logic [7:0] QUAL_BASE         = 8'd128;
    localparam logic [7:0] ROM_END           = 8'd138;

    localparam logic [5:0] DEV_LEN_M1        = 6'd17;
    localparam logic [5:0] CFG_SHORT_M1      = 6'd8;
    localparam logic [5:0] CFG_FULL_M1       = 6'd31;
    localparam logic [5:0] LANG_LEN_M1       = 6'd3;
    localparam logic [5:0] MAKER_LEN_M1      = 6'd43;
    localparam logic [5:0] PROD_LEN_M1       = 6'd29;
    localparam logic [5:0] QUAL_LEN_M1       = 6'd9;

    typedef struct packed {
        plan_kind_t  kind;
        action_t     action;
        logic [2:0]  status;
        logic        set_addr;
        logic [7:0]  base;
        logic [5:0]  cnt_m1;
    } plan_t;

endpackage

@@ hw/rtl/usr_decode.sv @@
module usr_decode (
    input  logic [7:0]     request_type,
    input  logic [7:0]     request_code,
    input  logic [7:0]     value_low,
    input  logic [7:0]     value_high,
    input  logic [7:0]     length_low,
    output usr_pkg::plan_t plan
);
    import usr_pkg::*;

    always_comb
    begin
        plan          = '0;
        plan.kind     = PLAN_SINGLE;
        plan.action   = ACT_ACK;
        plan.status   = STS_OK;
        plan.set_addr = 1'b0;
        plan.base     = DEV_BASE;
        plan.cnt_m1   = '0;
        if (request_type == RT_STD_OUT)
        begin
            if (request_code == REQ_SET_ADDRESS)
            begin
                plan.action   = ACT_SET_ADDR;
                plan.set_addr = 1'b1;
            end
            else if (request_code == REQ_SET_CONFIG)
            begin
                plan.action = ACT_CONFIG;
            end
            else
            begin
                plan.kind = PLAN_NONE;
            end
        end
        else if (request_type != RT_STD_IN)
        begin
            if ((request_type & RT_TYPE_MASK) == RT_TYPE_VENDOR)
                plan.status = STS_VENDOR;
            else
                plan.status = STS_BAD_TYPE;
        end
        else if (request_code == REQ_GET_STATUS)
        begin
            plan.status = STS_NO_STATUS;
        end
        else if (request_code != REQ_GET_DESC)
        begin
            plan.status = STS_BAD_REQUEST;
        end
        else
        begin
            plan.kind   = PLAN_STREAM;
            plan.action = ACT_DATA;
            case (value_high)
                DT_DEVICE:
                begin
                    plan.base   = DEV_BASE;
                    plan.cnt_m1 = DEV_LEN_M1;
                end
                DT_CONFIG:
                begin
                    plan.base   = CFG_BASE;
                    plan.cnt_m1 = (length_low == CFG_SHORT_LEN) ? CFG_SHORT_M1 : CFG_FULL_M1;
                end
                DT_STRING:
                begin
                    case (value_low)
                        STR_LANG:
                        begin
                            plan.base   = LANG_BASE;
                            plan.cnt_m1 = LANG_LEN_M1;
                        end
                        STR_MAKER:
                        begin
                            plan.base   = MAKER_BASE;
                            plan.cnt_m1 = MAKER_LEN_M1;
                        end
                        STR_PRODUCT:
                        begin
                            plan.base   = PROD_BASE;
                            plan.cnt_m1 = PROD_LEN_M1;
                        end
                        default:
                        begin
                            plan.kind   = PLAN_SINGLE;
                            plan.action = ACT_ACK;
                        end
                    endcase
                end
                DT_QUALIFIER:
                begin
                    plan.base   = QUAL_BASE;
                    plan.cnt_m1 = QUAL_LEN_M1;
                end
                default:
                begin
                    plan.kind   = PLAN_SINGLE;
                    plan.action = ACT_ACK;
                    plan.status = STS_BAD_DESC;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/usr_desc_rom.sv @@
module usr_desc_rom (
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] addr,
    output logic [7:0] q
);
    import usr_pkg::*;

    localparam logic [7:0] DEV_TAB [18] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
    };
    localparam logic [7:0] CFG_TAB [32] = '{
        8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'h00,
        8'h07, 8'h05, 8'h83, 8'h02, 8'h40, 8'h00, 8'h00,
        8'h07, 8'h05, 8'h04, 8'h02, 8'h40, 8'h00, 8'h00
    };
    localparam logic [7:0] LANG_TAB [4] = '{8'h04, 8'h03, 8'h09, 8'h04};
    localparam logic [7:0] MAKER_TAB [21] = '{
        8'h47, 8'h61, 8'h72, 8'h67, 8'h6f, 8'h79, 8'h6c, 8'h65, 8'h20, 8'h45, 8'h78,
        8'h74, 8'h65, 8'h6e, 8'h73, 8'h69, 8'h6f, 8'h6e, 8'h20, 8'h53, 8'h41
    };
    localparam logic [7:0] PROD_TAB [14] = '{
        8'h55, 8'h43, 8'h33, 8'h42, 8'h20, 8'h42, 8'h55, 8'h4c, 8'h4b, 8'h20,
        8'h54, 8'h45, 8'h53, 8'h54
    };
    localparam logic [7:0] QUAL_TAB [10] = '{
        8'h0A, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00
    };
    localparam logic [7:0] MAKER_HDR = 8'h2C;
    localparam logic [7:0] PROD_HDR  = 8'h1E;
    localparam logic [7:0] STR_DTYPE = 8'h03;

    logic [7:0] off;
    logic [7:0] chr;
    logic [7:0] rom_byte;
    logic [7:0] q_reg;

    always_comb
    begin
        off      = 8'd0;
        chr      = 8'd0;
        rom_byte = 8'd0;
        if (addr < CFG_BASE)
        begin
            off      = addr - DEV_BASE;
            rom_byte = DEV_TAB[off[4:0]];
        end
        else if (addr < LANG_BASE)
        begin
            off      = addr - CFG_BASE;
            rom_byte = CFG_TAB[off[4:0]];
        end
        else if (addr < MAKER_BASE)
        begin
            off      = addr - LANG_BASE;
            rom_byte = LANG_TAB[off[1:0]];
        end
        else if (addr < PROD_BASE)
        begin
            off = addr - MAKER_BASE;
            chr = off - 8'd2;
            if (off == 8'd0)
                rom_byte = MAKER_HDR;
            else if (off == 8'd1)
                rom_byte = STR_DTYPE;
            else if (!off[0])
                rom_byte = MAKER_TAB[chr[5:1]];
        end
        else if (addr < QUAL_BASE)
        begin
            off = addr - PROD_BASE;
            chr = off - 8'd2;
            if (off == 8'd0)
                rom_byte = PROD_HDR;
            else if (off == 8'd1)
                rom_byte = STR_DTYPE;
            else if (!off[0])
                rom_byte = PROD_TAB[chr[4:1]];
        end
        else if (addr < ROM_END)
        begin
            off      = addr - QUAL_BASE;
            rom_byte = QUAL_TAB[off[3:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= rom_byte;
    end

    assign q = q_reg;

endmodule

@@ hw/rtl/usb_setup_request_responder.sv @@
// USB standard setup request responder.
// Input channel: one setup request per beat (request_type, request_code,
// value_low, value_high, length_low), taken when in_valid is high and
// in_stall is low. Output channel: reply beats (action, data_byte, last,
// new_address, status) offered on out_valid and held while out_stall is high.
// Each request gives no beat (unsupported standard OUT request), one beat
// (set address, set configuration, acknowledge with a status code) or a
// descriptor stream of 4 to 44 bytes, the final beat flagged by last.
// Single-beat replies pass through the stage-1 and output registers; a
// descriptor stream is first read through the address register and the
// synchronous descriptor ROM read port, then runs at one byte per cycle
// while the receiver does not stall. No new request is taken until the
// final stream byte has been read from the ROM.
// Configuration writes (cfg_we, cfg_index, cfg_data) load vendor id,
// product id, release number and max power, patched into the descriptors.
// Reset clears the device address and restores default identifiers.
// When the receiver stalls, the output beat holds, one more beat waits in the
// ROM stage, and the sequencer and input side stall behind them.
module usb_setup_request_responder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [7:0]  value_low,
    input  logic [7:0]  value_high,
    input  logic [7:0]  length_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [6:0]  new_address,
    output logic [2:0]  status
);
    import usr_pkg::*;

    localparam logic [1:0] CFG_VENDOR  = 2'd0;
    localparam logic [1:0] CFG_PRODUCT = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;
    localparam logic [1:0] CFG_POWER   = 2'd3;

    plan_t      plan;
    seq_state_t state_reg, state_next;
    logic [7:0] addr_reg, addr_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [15:0] vid_reg, pid_reg, rel_reg;
    logic [7:0]  maxp_reg;
    logic [6:0]  dev_addr_reg;

    logic        s1_valid_reg;
    logic        s1_is_data_reg, s1_is_data_next;
    logic        s1_last_reg, s1_last_next;
    action_t     s1_action_reg, s1_action_next;
    logic [2:0]  s1_status_reg, s1_status_next;
    logic [7:0]  s1_addr_reg;
    logic [6:0]  s1_naddr_reg, s1_naddr_next;

    logic        out_valid_reg;
    action_t     out_action_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic [6:0]  out_naddr_reg;
    logic [2:0]  out_status_reg;

    logic        out_ready, s1_free, accept, s1_load, rom_en;
    logic [7:0]  rom_q, patched;

    usr_decode u_decode (
        .request_type (request_type),
        .request_code (request_code),
        .value_low    (value_low),
        .value_high   (value_high),
        .length_low   (length_low),
        .plan         (plan)
    );

    usr_desc_rom u_rom (
        .clk  (clk),
        .en   (rom_en),
        .addr (addr_reg),
        .q    (rom_q)
    );

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_ready;
    assign in_stall  = !((state_reg == ST_IDLE) && s1_free);
    assign accept    = in_valid && !in_stall;
    assign rom_en    = (state_reg == ST_STREAM) && s1_free;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        s1_load         = 1'b0;
        s1_is_data_next = 1'b0;
        s1_last_next    = 1'b1;
        s1_action_next  = plan.action;
        s1_status_next  = plan.status;
        s1_naddr_next   = dev_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (plan.kind)
                        PLAN_SINGLE:
                        begin
                            s1_load = 1'b1;
                            if (plan.set_addr)
                                s1_naddr_next = value_low[6:0];
                        end
                        PLAN_STREAM:
                        begin
                            addr_next  = plan.base;
                            cnt_next   = plan.cnt_m1;
                            state_next = ST_STREAM;
                        end
                        default:
                        begin
                            s1_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                s1_action_next = ACT_DATA;
                s1_status_next = STS_OK;
                if (s1_free)
                begin
                    s1_load         = 1'b1;
                    s1_is_data_next = 1'b1;
                    s1_last_next    = (cnt_reg == 6'd0);
                    addr_next       = addr_reg + 8'd1;
                    cnt_next        = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dev_addr_reg  <= '0;
            vid_reg       <= 16'h6666;
            pid_reg       <= 16'h89AB;
            rel_reg       <= 16'h0807;
            maxp_reg      <= 8'd50;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_ready)
                s1_valid_reg <= 1'b0;
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
            if (accept && plan.kind == PLAN_SINGLE && plan.set_addr)
                dev_addr_reg <= value_low[6:0];
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VENDOR:  vid_reg  <= cfg_data;
                    CFG_PRODUCT: pid_reg  <= cfg_data;
                    CFG_RELEASE: rel_reg  <= cfg_data;
                    CFG_POWER:   maxp_reg <= cfg_data[7:0];
                    default:     maxp_reg <= maxp_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_is_data_reg <= s1_is_data_next;
            s1_last_reg    <= s1_last_next;
            s1_action_reg  <= s1_action_next;
            s1_status_reg  <= s1_status_next;
            s1_addr_reg    <= addr_reg;
            s1_naddr_reg   <= s1_naddr_next;
        end
    end

    // patch configured fields into the fixed descriptor bytes
    always_comb
    begin
        case (s1_addr_reg)
            DEV_BASE + 8'd8:  patched = vid_reg[7:0];
            DEV_BASE + 8'd9:  patched = vid_reg[15:8];
            DEV_BASE + 8'd10: patched = pid_reg[7:0];
            DEV_BASE + 8'd11: patched = pid_reg[15:8];
            DEV_BASE + 8'd14: patched = rel_reg[7:0];
            DEV_BASE + 8'd15: patched = rel_reg[15:8];
            CFG_BASE + 8'd8:  patched = maxp_reg;
            default:          patched = rom_q;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_action_reg <= s1_action_reg;
            out_data_reg   <= s1_is_data_reg ? patched : 8'd0;
            out_last_reg   <= s1_last_reg;
            out_naddr_reg  <= s1_naddr_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_action_reg;
    assign data_byte   = out_data_reg;
    assign last        = out_last_reg;
    assign new_address = out_naddr_reg;
    assign status      = out_status_reg;

    a_rom_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |-> (addr_reg < ROM_END))
        else $error("descriptor read past end of ROM");

    a_stream_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM && s1_load && cnt_reg == 6'd0) |=>
        (s1_valid_reg && s1_last_reg && state_reg == ST_IDLE))
        else $error("final stream beat not flagged last");

    a_ctrl_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_action_reg != ACT_DATA) |->
        (out_last_reg && out_data_reg == 8'd0))
        else $error("control beat carries data or lacks last");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STREAM) |-> !accept)
        else $error("request taken during descriptor stream");

endmodule
